@@ rtl/ssrs_pkg.sv @@
package ssrs_pkg;

  localparam int ANGLE_W = 13;
  localparam int STEP_W = 12;
  localparam int TOL_W = 12;
  localparam int COUNT_W = 6;
  localparam int RANGE_W = 16;
  localparam int INDEX_W = 5;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int PROD_W = INDEX_W + STEP_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int DIFF_W = ANGLE_W + 1;

  localparam logic signed [ANGLE_W-1:0] START_RST = -13'sd400;
  localparam logic [STEP_W-1:0] STEP_RST = 12'd32;
  localparam logic [TOL_W-1:0] TOL_RST = 12'd24;
  localparam logic [COUNT_W-1:0] COUNT_RST = 6'd26;
  localparam logic [RANGE_W-1:0] NO_RETURN = 16'hFFFF;

  localparam logic signed [SUM_W-1:0] TARGET_MAX = 19'sd4095;
  localparam logic signed [SUM_W-1:0] TARGET_MIN = -19'sd4096;

  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START = 2'd0,
    CFG_STEP  = 2'd1,
    CFG_TOL   = 2'd2,
    CFG_COUNT = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SUM,
    ST_CHECK,
    ST_TARGET,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic capture;
    logic mult;
    logic sum;
    logic commit;
    logic load_target;
    logic load_sample;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic sweep_end;
    logic scan_last;
  } status_t;

endpackage

@@ rtl/ssrs_in_if.sv @@
interface ssrs_in_if;
  logic valid;
  logic ready;
  logic signed [12:0] measured_yaw;
  logic [15:0] range_reading;

  modport source (output valid, output measured_yaw, output range_reading, input ready);
  modport sink (input valid, input measured_yaw, input range_reading, output ready);
endinterface

@@ rtl/ssrs_out_if.sv @@
interface ssrs_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic signed [12:0] servo_target;
  logic [4:0] scan_index;
  logic [15:0] scan_range;
  logic last_of_run;

  modport source (output valid, output result_kind, output servo_target, output scan_index,
                  output scan_range, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input servo_target, input scan_index,
                input scan_range, input last_of_run, output ready);
endinterface

@@ rtl/ssrs_ctrl.sv @@
module ssrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssrs_pkg::status_t sts,
  output ssrs_pkg::cmd_t    cmd
);
  import ssrs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.mult = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.commit = 1'b1;
        state_next = ST_TARGET;
      end
      ST_TARGET: begin
        if (sts.out_free) begin
          cmd.load_target = 1'b1;
          state_next = sts.sweep_end ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.out_free) begin
          cmd.load_sample = 1'b1;
          if (sts.scan_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ssrs_datapath.sv @@
module ssrs_datapath #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    write_enable,
  input  logic [ssrs_pkg::CFG_INDEX_W-1:0]        write_index,
  input  logic [ssrs_pkg::CFG_DATA_W-1:0]         write_data,
  input  logic signed [ssrs_pkg::ANGLE_W-1:0]     measured_yaw,
  input  logic [ssrs_pkg::RANGE_W-1:0]            range_reading,
  input  ssrs_pkg::cmd_t                          cmd,
  output ssrs_pkg::status_t                       sts,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    result_kind,
  output logic signed [ssrs_pkg::ANGLE_W-1:0]     servo_target,
  output logic [ssrs_pkg::INDEX_W-1:0]            scan_index,
  output logic [ssrs_pkg::RANGE_W-1:0]            scan_range,
  output logic                                    last_of_run
);
  import ssrs_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // configuration
  logic signed [ANGLE_W-1:0] start_angle;
  logic [STEP_W-1:0] step_angle;
  logic [TOL_W-1:0] tolerance;
  logic [COUNT_W-1:0] sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= START_RST;
      step_angle <= STEP_RST;
      tolerance <= TOL_RST;
      sample_count <= COUNT_RST;
    end else if (write_enable) begin
      case (cfg_index_t'(write_index))
        CFG_START: start_angle <= write_data;
        CFG_STEP:  step_angle <= write_data[STEP_W-1:0];
        CFG_TOL:   tolerance <= write_data[TOL_W-1:0];
        CFG_COUNT: sample_count <= write_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sweep state
  logic [INDEX_W-1:0] step_index;
  logic moving_forward;

  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] n_m1;
  logic [INDEX_W-1:0] pos;

  always_comb begin
    if (sample_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (sample_count > COUNT_W'(MAX_SAMPLES)) begin
      n_eff = COUNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = sample_count;
    end
    n_m1 = n_eff - COUNT_W'(1);
    // position past the sweep end acts as the last position
    if ({1'b0, step_index} > n_m1) begin
      pos = n_m1[INDEX_W-1:0];
    end else begin
      pos = step_index;
    end
  end

  // captured tick
  logic signed [ANGLE_W-1:0] yaw;
  logic [RANGE_W-1:0] range_in;
  logic [PROD_W-1:0] prod;
  logic signed [ANGLE_W-1:0] target;

  logic signed [SUM_W-1:0] sum_w;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] err;
  logic settled;
  logic at_end;

  always_comb begin
    sum_w = $signed({{(SUM_W-ANGLE_W){start_angle[ANGLE_W-1]}}, start_angle})
          + $signed({2'b00, prod});
    diff = $signed({yaw[ANGLE_W-1], yaw}) - $signed({target[ANGLE_W-1], target});
    err = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    settled = err <= {{(DIFF_W-TOL_W){1'b0}}, tolerance};
    at_end = moving_forward ? ({1'b0, pos} >= n_m1) : (pos == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      yaw <= measured_yaw;
      range_in <= range_reading;
    end
    if (cmd.mult) begin
      prod <= {{STEP_W{1'b0}}, pos} * {{INDEX_W{1'b0}}, step_angle};
    end
    if (cmd.sum) begin
      if (sum_w > TARGET_MAX) begin
        target <= TARGET_MAX[ANGLE_W-1:0];
      end else if (sum_w < TARGET_MIN) begin
        target <= TARGET_MIN[ANGLE_W-1:0];
      end else begin
        target <= sum_w[ANGLE_W-1:0];
      end
    end
  end

  // next position, clamped to the sweep
  logic dir_new;
  logic [COUNT_W-1:0] pos_up;
  logic [INDEX_W-1:0] pos_adv;

  always_comb begin
    dir_new = at_end ? ~moving_forward : moving_forward;
    pos_up = {1'b0, pos} + COUNT_W'(1);
    if (pos_up > n_m1) begin
      pos_up = n_m1;
    end
    if (dir_new) begin
      pos_adv = pos_up[INDEX_W-1:0];
    end else if (pos == '0) begin
      pos_adv = '0;
    end else begin
      pos_adv = pos - INDEX_W'(1);
    end
  end

  logic sweep_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
      moving_forward <= 1'b1;
      sweep_end <= 1'b0;
    end else if (cmd.commit) begin
      sweep_end <= settled & at_end;
      if (settled) begin
        moving_forward <= dir_new;
        step_index <= pos_adv;
      end
    end
  end

  // range buffer, entries read as no return until written
  logic [RANGE_W-1:0] mem [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] written;
  logic [CW-1:0] scan_i;
  logic [CW-1:0] rd_sel;
  logic [RANGE_W-1:0] rd_data;
  logic rd_written;
  logic scan_last;

  assign scan_last = scan_i == CW'(n_m1);
  assign rd_sel = (cmd.load_sample && !scan_last) ? scan_i + CW'(1) : scan_i;

  always_ff @(posedge clk) begin
    if (cmd.commit && settled) begin
      mem[AW'(pos)] <= range_in;
    end
    rd_data <= mem[AW'(rd_sel)];
    rd_written <= written[AW'(rd_sel)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (cmd.commit && settled) begin
      written[AW'(pos)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0;
    end else if (cmd.commit) begin
      scan_i <= '0;
    end else if (cmd.load_sample && !scan_last) begin
      scan_i <= scan_i + CW'(1);
    end
  end

  // output register
  logic out_free;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_target || cmd.load_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_target) begin
      result_kind <= KIND_TARGET;
      servo_target <= target;
      scan_index <= '0;
      scan_range <= '0;
      last_of_run <= ~sweep_end;
    end else if (cmd.load_sample) begin
      result_kind <= KIND_SAMPLE;
      servo_target <= '0;
      scan_index <= INDEX_W'(scan_i);
      scan_range <= rd_written ? rd_data : NO_RETURN;
      last_of_run <= scan_last;
    end
  end

  always_comb begin
    sts.out_free = out_free;
    sts.sweep_end = sweep_end;
    sts.scan_last = scan_last;
  end

endmodule

@@ rtl/servo_sweep_range_scanner_core.sv @@
// Servo target result is registered via ST_CALC, ST_SUM, ST_CHECK and ST_TARGET.
// A tick that ends a sweep then streams one scan sample per cycle (n positions)
// while the output register is free, paced by the single read port of the range
// buffer; the next tick is taken once the last result of the current one is in
// the output register. Loads into that register wait on result.ready.
// Reset (rst, synchronous) restores the register defaults, position 0 moving
// forward, and makes every buffer entry read as no return until written.
module servo_sweep_range_scanner_core #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [ssrs_pkg::CFG_INDEX_W-1:0]  write_index,
  input  logic [ssrs_pkg::CFG_DATA_W-1:0]   write_data,
  ssrs_in_if.sink                           tick,
  ssrs_out_if.source                        result
);
  import ssrs_pkg::*;

  cmd_t cmd;
  status_t sts;

  ssrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (tick.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssrs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .write_enable  (write_enable),
    .write_index   (write_index),
    .write_data    (write_data),
    .measured_yaw  (tick.measured_yaw),
    .range_reading (tick.range_reading),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .result_kind   (result.result_kind),
    .servo_target  (result.servo_target),
    .scan_index    (result.scan_index),
    .scan_range    (result.scan_range),
    .last_of_run   (result.last_of_run)
  );

endmodule
